>>> hw/rtl/idss_pkg.sv
package idss_pkg;

  // Lane count limits and the fixed widths of the item fields.
  localparam int MAX_LANES     = 3;
  localparam int LANES_DEFAULT = 3;
  localparam int POS_W         = 32;
  localparam int FREQ_W        = 16;
  localparam int ZETA_W        = 16;
  localparam int STEP_W        = 24;
  localparam int LANE_CNT_W    = 2;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 24;

  // Internal datapath widths, set by the fixed point formats.
  localparam int OMEGA_W   = 27;
  localparam int HO_W      = 31;
  localparam int F_W       = 37;
  localparam int HOO_W     = 42;
  localparam int HHOO_W    = 46;
  localparam int DEN_W     = 47;
  localparam int QUO_W     = 42;
  localparam int ACC_W     = 48;
  localparam int TERM_W    = 77;
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int CHUNK_W   = 21;
  localparam int COEF_FRAC = 30;
  localparam int STEP_FRAC = 26;

  // Arithmetic constants.
  localparam logic [18:0]       TWO_PI_Q16 = 19'd411775;
  localparam logic [F_W-1:0]    ONE_Q16    = F_W'(65536);
  localparam logic [ZETA_W-1:0] ZETA_ONE   = 16'd4096;

  // Configuration reset values.
  localparam logic [FREQ_W-1:0]     FREQ_RESET     = 16'd1024;
  localparam logic [ZETA_W-1:0]     ZETA_RESET     = 16'd4096;
  localparam logic [FREQ_W-1:0]     DEF_FREQ_RESET = 16'd1024;
  localparam logic [STEP_W-1:0]     MAX_STEP_RESET = 24'd104858;
  localparam logic [LANE_CNT_W-1:0] LANES_RESET    = 2'd3;

  // Operation codes of an input item.
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_RESET = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FREQUENCY    = 3'd0,
    CFG_DAMPING      = 3'd1,
    CFG_DEFAULT_FREQ = 3'd2,
    CFG_MAX_STEP     = 3'd3,
    CFG_ACTIVE_LANES = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_STEP,
    KIND_RESET
  } kind_t;

  // One classified command, as it waits between front and back.
  typedef struct packed {
    kind_t                        kind;
    logic [LANE_CNT_W-1:0]        lanes;
    logic [STEP_W-1:0]            h;
    logic [FREQ_W-1:0]            freq;
    logic [ZETA_W-1:0]            zeta;
    logic [MAX_LANES*POS_W-1:0]   target;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = MAX_LANES * POS_W;

  // Queue status seen by the back end, and its requests to the queues.
  typedef struct packed {
    logic cmd_empty;
    logic res_full;
  } queue_status_t;

  typedef struct packed {
    logic cmd_pop;
    logic res_push;
  } back_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OMEGA_MUL,
    ST_OMEGA,
    ST_HO_MUL,
    ST_HO,
    ST_F_MUL,
    ST_HOO_MUL,
    ST_HHOO_MUL,
    ST_HHOO,
    ST_DIV_LOAD,
    ST_DIV,
    ST_LANE,
    ST_PUSH
  } back_state_t;

  // Clamp a wide signed sum to the signed 32 bit range.
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic all_same;
    begin
      all_same = (v[ACC_W-1:POS_W-1] == '0) || (v[ACC_W-1:POS_W-1] == '1);
      if (all_same) begin
        sat32 = v[POS_W-1:0];
      end else if (v[ACC_W-1]) begin
        sat32 = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        sat32 = {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  endfunction

endpackage

>>> hw/rtl/idss_fifo.sv
module idss_fifo import idss_pkg::*; #(
  parameter int W     = CMD_W,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wr_data,
  input  logic         rd,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/idss_front.sv
module idss_front import idss_pkg::*; #(
  parameter int LANES = LANES_DEFAULT
) (
  input  logic                     push,
  input  logic                     operation,
  input  logic signed [POS_W-1:0]  target_x,
  input  logic signed [POS_W-1:0]  target_y,
  input  logic signed [POS_W-1:0]  target_z,
  input  logic [STEP_W-1:0]        delta_time,
  input  logic [FREQ_W-1:0]        frequency,
  input  logic [ZETA_W-1:0]        damping_ratio,
  input  logic [FREQ_W-1:0]        default_frequency,
  input  logic [STEP_W-1:0]        max_step,
  input  logic [LANE_CNT_W-1:0]    active_lanes,
  input  logic                     queue_full,
  output logic                     queue_wr,
  output cmd_t                     cmd
);

  logic [LANE_CNT_W-1:0] lanes;

  // Lanes that an item may touch, limited by the built lane count.
  assign lanes = (active_lanes > LANE_CNT_W'(LANES)) ? LANE_CNT_W'(LANES) : active_lanes;

  assign queue_wr = push && !queue_full;

  // Classify the item and resolve the defaults and the step clamp.
  always_comb begin
    cmd.lanes  = lanes;
    cmd.h      = (delta_time < max_step) ? delta_time : max_step;
    cmd.freq   = (frequency != '0) ? frequency : default_frequency;
    cmd.zeta   = (damping_ratio != '0) ? damping_ratio : ZETA_ONE;
    cmd.target = {target_z, target_y, target_x};
    if (operation == OP_RESET) begin
      cmd.kind = KIND_RESET;
    end else if (delta_time == '0 || lanes == '0) begin
      cmd.kind = KIND_HOLD;
    end else begin
      cmd.kind = KIND_STEP;
    end
  end

endmodule

>>> hw/rtl/idss_div.sv
module idss_div import idss_pkg::*; #(
  parameter int FRAC = COEF_FRAC
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             busy
);

  localparam int NW = DEN_W + FRAC;
  localparam int CW = $clog2(QUO_W + 1);

  logic [NW-1:0]    n_full;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W-1:0] rem_next;
  logic [CW-1:0]    cnt;

  // The scaled numerator; its top part is already below the divisor.
  assign n_full   = {num, {FRAC{1'b0}}};
  assign trial    = {rem, quo[QUO_W-1]};
  assign fits     = (trial >= {1'b0, den});
  assign rem_next = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem  <= DEN_W'(n_full[NW-1:QUO_W]);
      quo  <= n_full[QUO_W-1:0];
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[QUO_W-2:0], fits};
      cnt <= cnt + 1'b1;
      if (cnt == CW'(QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/idss_back.sv
module idss_back import idss_pkg::*; #(
  parameter int LANES = LANES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  queue_status_t    status,
  output back_req_t        req,
  output logic [RES_W-1:0] result
);

  localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [3:0] SUB_WRITE      = 4'd11;
  localparam logic [2:0] TERMS_X        = 3'd3;

  back_state_t state;
  back_state_t state_next;

  cmd_t                          item;
  logic signed [POS_W-1:0]       position [LANES];
  logic signed [POS_W-1:0]       speed [LANES];
  logic [OMEGA_W-1:0]            omega;
  logic [HO_W-1:0]               ho;
  logic [F_W-1:0]                f;
  logic [HOO_W-1:0]              hoo;
  logic [HHOO_W-1:0]             hhoo;
  logic signed [MUL_P_W-1:0]     mul_p;
  logic signed [TERM_W-1:0]      tacc;
  logic signed [ACC_W-1:0]       nx;
  logic signed [ACC_W-1:0]       nv;
  logic [LANE_CNT_W-1:0]         lane;
  logic [3:0]                    sub;

  logic signed [MUL_A_W-1:0]     op_a;
  logic signed [MUL_B_W-1:0]     op_b;
  logic [IW-1:0]                 lane_idx;
  logic signed [POS_W-1:0]       x_old;
  logic signed [POS_W-1:0]       v_old;
  logic signed [POS_W-1:0]       t_lane;
  logic [2:0]                    issue_term;
  logic [2:0]                    done_term;
  logic [3:0]                    sub_prev;
  logic signed [MUL_A_W-1:0]     term_p;
  logic [QUO_W-1:0]              term_k;
  logic signed [TERM_W-1:0]      term_sum;
  logic signed [ACC_W-1:0]       term_q;

  logic                          div_start;
  logic [DEN_W-1:0]              den;
  logic [QUO_W-1:0]              qa, qb, qc, qg, qd;
  logic [4:0]                    div_busy;

  // Shared divisor of all five coefficients.
  assign den       = DEN_W'(f) + DEN_W'(hhoo);
  assign div_start = (state == ST_DIV_LOAD);

  idss_div #(.FRAC(COEF_FRAC)) u_div_a (
    .clk(clk), .rst(rst), .start(div_start), .num(DEN_W'(f)), .den(den),
    .quo(qa), .busy(div_busy[0])
  );
  idss_div #(.FRAC(COEF_FRAC)) u_div_b (
    .clk(clk), .rst(rst), .start(div_start), .num(DEN_W'(hhoo)), .den(den),
    .quo(qb), .busy(div_busy[1])
  );
  idss_div #(.FRAC(STEP_FRAC)) u_div_c (
    .clk(clk), .rst(rst), .start(div_start), .num(DEN_W'(item.h)), .den(den),
    .quo(qc), .busy(div_busy[2])
  );
  idss_div #(.FRAC(COEF_FRAC)) u_div_g (
    .clk(clk), .rst(rst), .start(div_start), .num(DEN_W'(ONE_Q16)), .den(den),
    .quo(qg), .busy(div_busy[3])
  );
  idss_div #(.FRAC(COEF_FRAC)) u_div_d (
    .clk(clk), .rst(rst), .start(div_start), .num(DEN_W'(hoo)), .den(den),
    .quo(qd), .busy(div_busy[4])
  );

  // Operands of the current lane.
  assign lane_idx = lane[IW-1:0];
  assign x_old    = position[lane_idx];
  assign v_old    = speed[lane_idx];
  assign t_lane   = item.target[lane_idx*POS_W +: POS_W];

  // Term schedule: two partial products per term; each product is registered and used in the next cycle.
  assign issue_term = sub[3:1];
  assign sub_prev   = sub - 1'b1;
  assign done_term  = sub_prev[3:1];

  always_comb begin
    case (issue_term)
      3'd0: begin
        term_p = MUL_A_W'(x_old);
        term_k = qa;
      end
      3'd1: begin
        term_p = MUL_A_W'(v_old);
        term_k = qc;
      end
      3'd2: begin
        term_p = MUL_A_W'(t_lane);
        term_k = qb;
      end
      3'd3: begin
        term_p = MUL_A_W'(v_old);
        term_k = qg;
      end
      3'd4: begin
        term_p = MUL_A_W'(t_lane) - MUL_A_W'(x_old);
        term_k = qd;
      end
      default: begin
        term_p = '0;
        term_k = '0;
      end
    endcase
  end

  // Operand selection of the one shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_OMEGA_MUL: begin
        op_a = MUL_A_W'(item.freq);
        op_b = MUL_B_W'(TWO_PI_Q16);
      end
      ST_HO_MUL: begin
        op_a = MUL_A_W'(item.h);
        op_b = MUL_B_W'(omega);
      end
      ST_F_MUL: begin
        op_a = MUL_A_W'(ho);
        op_b = MUL_B_W'(item.zeta);
      end
      ST_HOO_MUL: begin
        op_a = MUL_A_W'(ho);
        op_b = MUL_B_W'(omega);
      end
      ST_HHOO_MUL: begin
        op_a = MUL_A_W'(ho);
        op_b = MUL_B_W'(ho);
      end
      ST_LANE: begin
        op_a = term_p;
        op_b = sub[0] ? MUL_B_W'(term_k[QUO_W-1:CHUNK_W]) : MUL_B_W'(term_k[CHUNK_W-1:0]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Whole term from its two partial products, floored to Q16.16.
  assign term_sum = tacc + (TERM_W'(mul_p) <<< CHUNK_W);
  assign term_q   = ACC_W'(signed'(term_sum[TERM_W-1:COEF_FRAC]));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and queue requests.
  always_comb begin
    state_next   = state;
    req.cmd_pop  = 1'b0;
    req.res_push = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!status.cmd_empty) begin
          req.cmd_pop = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = (item.kind == KIND_STEP) ? ST_OMEGA_MUL : ST_PUSH;
      end
      ST_OMEGA_MUL: state_next = ST_OMEGA;
      ST_OMEGA:     state_next = ST_HO_MUL;
      ST_HO_MUL:    state_next = ST_HO;
      ST_HO:        state_next = ST_F_MUL;
      ST_F_MUL:     state_next = ST_HOO_MUL;
      ST_HOO_MUL:   state_next = ST_HHOO_MUL;
      ST_HHOO_MUL:  state_next = ST_HHOO;
      ST_HHOO:      state_next = ST_DIV_LOAD;
      ST_DIV_LOAD:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_busy == '0) begin
          state_next = ST_LANE;
        end
      end
      ST_LANE: begin
        if (sub == SUB_WRITE && (lane + 1'b1) == item.lanes) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!status.res_full) begin
          req.res_push = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers and the spring state.
  always_ff @(posedge clk) begin
    mul_p <= op_a * op_b;
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        position[i] <= '0;
        speed[i]    <= '0;
      end
      lane <= '0;
      sub  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!status.cmd_empty) begin
            item <= cmd;
          end
        end
        ST_DECODE: begin
          lane <= '0;
          sub  <= '0;
          if (item.kind == KIND_RESET) begin
            for (int i = 0; i < LANES; i++) begin
              if (LANE_CNT_W'(i) < item.lanes) begin
                position[i] <= item.target[i*POS_W +: POS_W];
                speed[i]    <= '0;
              end
            end
          end
        end
        ST_OMEGA:    omega <= mul_p[34:8];
        ST_HO:       ho    <= mul_p[50:20];
        ST_HOO_MUL:  f     <= ONE_Q16 + F_W'(mul_p[46:11]);
        ST_HHOO_MUL: hoo   <= mul_p[57:16];
        ST_HHOO:     hhoo  <= mul_p[61:16];
        ST_LANE: begin
          if (sub == '0) begin
            nx <= '0;
            nv <= '0;
          end else if (sub != SUB_WRITE) begin
            if (!sub_prev[0]) begin
              tacc <= TERM_W'(mul_p);
            end else if (done_term < TERMS_X) begin
              nx <= nx + term_q;
            end else begin
              nv <= nv + term_q;
            end
          end
          if (sub == SUB_WRITE) begin
            position[lane_idx] <= sat32(nx);
            speed[lane_idx]    <= sat32(nv);
            lane               <= lane + 1'b1;
            sub                <= '0;
          end else begin
            sub <= sub + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Held positions; lanes that are not built read as zero.
  for (genvar i = 0; i < MAX_LANES; i++) begin : g_result
    if (i < LANES) begin : g_lane
      assign result[i*POS_W +: POS_W] = position[i];
    end else begin : g_none
      assign result[i*POS_W +: POS_W] = '0;
    end
  end

endmodule

>>> hw/rtl/implicit_damped_spring_step_top.sv
// Damped spring with up to three lanes, advanced one implicit Euler step per
// item toward the item's targets; a reset item loads the active lanes'
// positions from the targets and clears their speeds, and every item returns
// the held positions. Items enter through a two-entry command queue and
// results leave through a two-entry result queue, so both sides may stall
// freely. In the back end, reset items, zero time steps and items with no
// active lane pass the idle state, which takes the item, the decode state
// and the push state, which queues the result. A step also has the shared
// multiplier form the step terms and start the dividers, then waits on the
// five restoring dividers (one quotient bit per cycle over 42 bits) that
// produce the coefficients, and then forms ten partial products per lane on
// the same multiplier. Items are processed one at a time.
module implicit_damped_spring_step_top import idss_pkg::*; #(
  parameter int LANES = LANES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic                     operation,
  input  logic signed [POS_W-1:0]  target_x,
  input  logic signed [POS_W-1:0]  target_y,
  input  logic signed [POS_W-1:0]  target_z,
  input  logic [STEP_W-1:0]        delta_time,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [POS_W-1:0]  position_x,
  output logic signed [POS_W-1:0]  position_y,
  output logic signed [POS_W-1:0]  position_z,
  input  logic                     write_enable,
  input  logic [CFG_INDEX_W-1:0]   write_index,
  input  logic [CFG_DATA_W-1:0]    write_data
);

  logic [FREQ_W-1:0]     frequency;
  logic [ZETA_W-1:0]     damping_ratio;
  logic [FREQ_W-1:0]     default_frequency;
  logic [STEP_W-1:0]     max_step;
  logic [LANE_CNT_W-1:0] active_lanes;

  cmd_t             front_cmd;
  logic             cmd_wr;
  logic [CMD_W-1:0] cmd_rd_data;
  logic             cmd_empty;
  logic             res_full;
  logic [RES_W-1:0] back_result;
  logic [RES_W-1:0] res_data;
  queue_status_t    status;
  back_req_t        req;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frequency         <= FREQ_RESET;
      damping_ratio     <= ZETA_RESET;
      default_frequency <= DEF_FREQ_RESET;
      max_step          <= MAX_STEP_RESET;
      active_lanes      <= LANES_RESET;
    end else if (write_enable) begin
      case (cfg_index_t'(write_index))
        CFG_FREQUENCY:    frequency         <= write_data[FREQ_W-1:0];
        CFG_DAMPING:      damping_ratio     <= write_data[ZETA_W-1:0];
        CFG_DEFAULT_FREQ: default_frequency <= write_data[FREQ_W-1:0];
        CFG_MAX_STEP:     max_step          <= write_data[STEP_W-1:0];
        CFG_ACTIVE_LANES: active_lanes      <= write_data[LANE_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: classify each item.
  idss_front #(.LANES(LANES)) u_front (
    .push(push),
    .operation(operation),
    .target_x(target_x),
    .target_y(target_y),
    .target_z(target_z),
    .delta_time(delta_time),
    .frequency(frequency),
    .damping_ratio(damping_ratio),
    .default_frequency(default_frequency),
    .max_step(max_step),
    .active_lanes(active_lanes),
    .queue_full(full),
    .queue_wr(cmd_wr),
    .cmd(front_cmd)
  );

  // Command queue between front and back.
  idss_fifo #(.W(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk(clk),
    .rst(rst),
    .wr(cmd_wr),
    .wr_data(front_cmd),
    .rd(req.cmd_pop),
    .rd_data(cmd_rd_data),
    .full(full),
    .empty(cmd_empty)
  );

  assign status.cmd_empty = cmd_empty;
  assign status.res_full  = res_full;

  // Back end: coefficients and lane updates.
  idss_back #(.LANES(LANES)) u_back (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_t'(cmd_rd_data)),
    .status(status),
    .req(req),
    .result(back_result)
  );

  // Result queue toward the consumer.
  idss_fifo #(.W(RES_W), .DEPTH(2)) u_res_q (
    .clk(clk),
    .rst(rst),
    .wr(req.res_push),
    .wr_data(back_result),
    .rd(pop),
    .rd_data(res_data),
    .full(res_full),
    .empty(empty)
  );

  assign position_x = res_data[0*POS_W +: POS_W];
  assign position_y = res_data[1*POS_W +: POS_W];
  assign position_z = res_data[2*POS_W +: POS_W];

endmodule

>>> dv/tb_implicit_damped_spring_step_top.sv
`timescale 1ns / 1ps

module tb_implicit_damped_spring_step_top;
  import idss_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 150;

  typedef struct {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
  } positions_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  logic                    operation = OP_STEP;
  logic signed [POS_W-1:0] target_x = '0;
  logic signed [POS_W-1:0] target_y = '0;
  logic signed [POS_W-1:0] target_z = '0;
  logic [STEP_W-1:0]       delta_time = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [POS_W-1:0] position_x;
  logic signed [POS_W-1:0] position_y;
  logic signed [POS_W-1:0] position_z;
  logic                    write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0]  write_index = '0;
  logic [CFG_DATA_W-1:0]   write_data = '0;

  // Shadow copy of the spring state and the configuration.
  logic signed [POS_W-1:0]  spring_pos [3];
  logic signed [POS_W-1:0]  spring_vel [3];
  logic [FREQ_W-1:0]        freq_reg;
  logic [ZETA_W-1:0]        zeta_reg;
  logic [FREQ_W-1:0]        def_freq_reg;
  logic [STEP_W-1:0]        max_step_reg;
  logic [LANE_CNT_W-1:0]    lanes_reg;

  positions_t expected_positions [$];
  int         mismatches = 0;
  bit         idling = 1'b1;
  int         quiet_cycles = 0;

  implicit_damped_spring_step_top u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .delta_time(delta_time), .empty(empty), .pop(pop),
    .position_x(position_x), .position_y(position_y), .position_z(position_z),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data)
  );

  always #5 clk = ~clk;

  // Coefficient as floor(num * 2^bits / den).
  function automatic logic [127:0] coef_div(input logic [127:0] num, input logic [127:0] den,
                                            input int bits);
    return (num << bits) / den;
  endfunction

  // Floor of p * k / 2^30.
  function automatic logic signed [127:0] scale_q30(input logic signed [127:0] p,
                                                    input logic [127:0] k);
    logic signed [127:0] prod;
    prod = p * $signed(k);
    return prod >>> COEF_FRAC;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -128'sh80000000) return 32'h80000000;
    return v[POS_W-1:0];
  endfunction

  // Advance the shadow spring by one item and return the positions it holds.
  function automatic positions_t spring_advance(input logic op,
                                                input logic signed [POS_W-1:0] tx,
                                                input logic signed [POS_W-1:0] ty,
                                                input logic signed [POS_W-1:0] tz,
                                                input logic [STEP_W-1:0] dt);
    logic signed [POS_W-1:0] tgt [3];
    logic [127:0] h, fr, z, omega, ho, f, hoo, hhoo, den, ka, kb, kc, kg, kd;
    logic signed [127:0] x, v, t, nx, nv;
    int lanes;
    positions_t r;
    tgt[0] = tx;
    tgt[1] = ty;
    tgt[2] = tz;
    lanes = (int'(lanes_reg) > 3) ? 3 : int'(lanes_reg);
    if (op == OP_RESET) begin
      for (int i = 0; i < lanes; i++) begin
        spring_pos[i] = tgt[i];
        spring_vel[i] = '0;
      end
    end else if (dt != '0) begin
      h = (dt < max_step_reg) ? 128'(dt) : 128'(max_step_reg);
      fr = (freq_reg != '0) ? 128'(freq_reg) : 128'(def_freq_reg);
      z = (zeta_reg != '0) ? 128'(zeta_reg) : 128'(ZETA_ONE);
      omega = (fr * 128'(TWO_PI_Q16)) >> 8;
      ho = (h * omega) >> 20;
      f = 128'(65536) + ((ho * z) >> 11);
      hoo = (ho * omega) >> 16;
      hhoo = (ho * ho) >> 16;
      den = f + hhoo;
      ka = coef_div(f, den, 30);
      kb = coef_div(hhoo, den, 30);
      kc = coef_div(h, den, 26);
      kg = coef_div(128'(65536), den, 30);
      kd = coef_div(hoo, den, 30);
      for (int i = 0; i < lanes; i++) begin
        x = 128'(spring_pos[i]);
        v = 128'(spring_vel[i]);
        t = 128'(tgt[i]);
        nx = scale_q30(x, ka) + scale_q30(v, kc) + scale_q30(t, kb);
        nv = scale_q30(v, kg) + scale_q30(t - x, kd);
        spring_pos[i] = clamp32(nx);
        spring_vel[i] = clamp32(nv);
      end
    end
    r.px = spring_pos[0];
    r.py = spring_pos[1];
    r.pz = spring_pos[2];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [POS_W-1:0] got,
                                 input logic [POS_W-1:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  // Result side: random pop stalls and comparison against the oldest expectation.
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      pop <= 1'b0;
      stall = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_positions.size() == 0) begin
          report_mismatch("unexpected item", position_x, '0);
        end else begin
          positions_t e;
          e = expected_positions.pop_front();
          if (position_x !== e.px) report_mismatch("position_x", position_x, e.px);
          if (position_y !== e.py) report_mismatch("position_y", position_y, e.py);
          if (position_z !== e.pz) report_mismatch("position_z", position_z, e.pz);
        end
      end
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall = int'($urandom_range(0, 7));
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || write_enable || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one item; push stays high after acceptance so back-to-back items stream.
  task automatic send_item(input logic op, input logic signed [POS_W-1:0] tx,
                           input logic signed [POS_W-1:0] ty,
                           input logic signed [POS_W-1:0] tz, input logic [STEP_W-1:0] dt);
    if (idling && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    push <= 1'b1;
    operation <= op;
    target_x <= tx;
    target_y <= ty;
    target_z <= tz;
    delta_time <= dt;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_positions.push_back(spring_advance(op, tx, ty, tz, dt));
  endtask

  // Stop sending and wait for every expected item to come back.
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      CFG_FREQUENCY:    freq_reg = data[FREQ_W-1:0];
      CFG_DAMPING:      zeta_reg = data[ZETA_W-1:0];
      CFG_DEFAULT_FREQ: def_freq_reg = data[FREQ_W-1:0];
      CFG_MAX_STEP:     max_step_reg = data[STEP_W-1:0];
      CFG_ACTIVE_LANES: lanes_reg = data[LANE_CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] fq, input logic [15:0] zt,
                           input logic [15:0] dfq, input logic [23:0] ms,
                           input logic [1:0] ln);
    write_reg(CFG_FREQUENCY, CFG_DATA_W'(fq));
    write_reg(CFG_DAMPING, CFG_DATA_W'(zt));
    write_reg(CFG_DEFAULT_FREQ, CFG_DATA_W'(dfq));
    write_reg(CFG_MAX_STEP, CFG_DATA_W'(ms));
    write_reg(CFG_ACTIVE_LANES, CFG_DATA_W'(ln));
  endtask

  function automatic logic signed [POS_W-1:0] pick_target();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return STEP_W'($urandom);
      3: return STEP_W'($urandom_range(1, 64));
      default: return STEP_W'($urandom_range(1, 200000));
    endcase
  endfunction

  // Extremes of the fields, both operations, zero step and saturation, at reset config and at several written configs.
  task automatic test_directed();
    send_item(OP_STEP, 32'sh00010000, -32'sh00010000, 32'sh7FFFFFFF, 24'd0);
    send_item(OP_RESET, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 24'hFFFFFF);
    send_item(OP_STEP, 32'sh80000000, 32'sh7FFFFFFF, 32'sh00000001, 24'hFFFFFF);
    send_item(OP_STEP, 32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF, 24'd1);
    send_item(OP_STEP, 32'sh00050000, 32'sh00050000, 32'sh00050000, 24'd16384);
    send_item(OP_STEP, 32'sh00050000, 32'sh00050000, 32'sh00050000, 24'd0);
    wait_drained();
    // Both frequencies zero: the position drifts with the speed.
    write_all(16'd0, 16'd0, 16'd0, 24'hFFFFFF, 2'd3);
    send_item(OP_STEP, 32'sh7FFFFFFF, 32'sh80000000, 32'sh12345678, 24'hFFFFFF);
    send_item(OP_STEP, 32'sh7FFFFFFF, 32'sh80000000, 32'sh12345678, 24'h800000);
    wait_drained();
    // Zero maximum step, then the fastest and stiffest spring.
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd0, 2'd2);
    send_item(OP_STEP, 32'sh40000000, -32'sh40000000, 32'sh40000000, 24'hFFFFFF);
    wait_drained();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 2'd1);
    send_item(OP_RESET, 32'sh7FFFFFFF, 32'sh00010000, 32'sh00020000, 24'd0);
    send_item(OP_STEP, 32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hFFFFFF);
    send_item(OP_STEP, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'd1);
    wait_drained();
    // No active lane: nothing moves on steps or resets.
    write_all(16'd0, 16'd1, 16'd1, 24'd1, 2'd0);
    send_item(OP_RESET, 32'sh11111111, 32'sh22222222, 32'sh33333333, 24'd5);
    send_item(OP_STEP, 32'sh11111111, 32'sh22222222, 32'sh33333333, 24'd5);
    wait_drained();
    write_all(FREQ_RESET, 16'd0, DEF_FREQ_RESET, MAX_STEP_RESET, LANES_RESET);
    send_item(OP_STEP, 32'sh00100000, 32'sh00100000, 32'sh00100000, 24'd50000);
    send_item(OP_STEP, 32'sh00100000, 32'sh00100000, 32'sh00100000, 24'd50000);
    wait_drained();
  endtask

  // Random items over many register settings; the last phase runs without idling.
  task automatic test_random();
    int phases;
    phases = 12;
    for (int p = 0; p < phases; p++) begin
      logic [15:0] fq, zt, dfq;
      logic [23:0] ms;
      fq = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(64, 8192));
      if ($urandom_range(0, 5) == 0) fq = 16'hFFFF;
      zt = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
      dfq = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
      ms = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 300000));
      write_all(fq, zt, dfq, ms, 2'($urandom_range(0, 3)));
      if (p == phases - 1) idling = 1'b0;
      for (int n = 0; n < 110; n++) begin
        if (p == 5 && n == 55) wait_drained();
        send_item(($urandom_range(0, 15) == 0) ? OP_RESET : OP_STEP,
                  pick_target(), pick_target(), pick_target(), pick_step());
      end
      wait_drained();
    end
  endtask

  initial begin
    freq_reg = FREQ_RESET;
    zeta_reg = ZETA_RESET;
    def_freq_reg = DEF_FREQ_RESET;
    max_step_reg = MAX_STEP_RESET;
    lanes_reg = LANES_RESET;
    for (int i = 0; i < 3; i++) begin
      spring_pos[i] = '0;
      spring_vel[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/idss_pkg.sv
hw/rtl/idss_fifo.sv
hw/rtl/idss_front.sv
hw/rtl/idss_div.sv
hw/rtl/idss_back.sv
hw/rtl/implicit_damped_spring_step_top.sv
dv/tb_implicit_damped_spring_step_top.sv
